### hdl/slsf_pkg.sv
package slsf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SUM_W  = 16;   // largest frame sum stays below 2**16
    localparam int unsigned CHK_W  = 32;

    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN  = 8'd5;
    localparam logic [BYTE_W-1:0] SUM_BYTES      = 8'd4;
    localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET  = 8'd200;

    // configuration register indexes
    localparam logic REG_SYNC_BYTE  = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_end;
        logic              checksum_ok;
        logic [BYTE_W-1:0] message_id;
    } result_t;

endpackage

### hdl/slsf_parser.sv
module slsf_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [slsf_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [slsf_pkg::BYTE_W-1:0]     sync_byte,
    input  logic [slsf_pkg::BYTE_W-1:0]     max_length,
    output logic                            res_valid,
    output slsf_pkg::result_t               res
);
    import slsf_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0] byte_count_reg, byte_count_next;
    logic [SUM_W-1:0]  running_sum_reg, running_sum_next;
    logic [CHK_W-1:0]  received_sum_reg, received_sum_next;
    logic [BYTE_W-1:0] held_id_reg, held_id_next;

    logic [BYTE_W-1:0] payload_len;
    logic [1:0]        lane_diff;
    logic [BYTE_W-1:0] count_inc;
    logic [SUM_W-1:0]  sum_plus;
    logic [CHK_W-1:0]  received_ins;
    logic              emit;
    logic              end_now;

    assign payload_len = frame_length_reg - SUM_BYTES;
    // low two bits of count minus length give the checksum lane
    assign lane_diff   = byte_count_reg[1:0] - frame_length_reg[1:0];
    assign count_inc   = byte_count_reg + 8'd1;
    assign sum_plus    = running_sum_reg + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};

    always_comb begin
        received_ins = received_sum_reg;
        case (lane_diff)
            2'd0:    received_ins[7:0]   = rx_byte;
            2'd1:    received_ins[15:8]  = rx_byte;
            2'd2:    received_ins[23:16] = rx_byte;
            default: received_ins[31:24] = rx_byte;
        endcase
    end

    always_comb begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        received_sum_next  = received_sum_reg;
        held_id_next       = held_id_reg;
        emit               = 1'b0;
        end_now            = 1'b0;
        res.out_byte       = '0;
        res.byte_index     = '0;
        res.frame_end      = 1'b0;
        res.checksum_ok    = 1'b0;
        res.message_id     = '0;
        unique case (phase_reg)
            PH_LEN: begin
                if (rx_byte < MIN_FRAME_LEN || rx_byte >= max_length) begin
                    phase_next        = PH_HUNT;
                    frame_length_next = '0;
                    byte_count_next   = '0;
                    running_sum_next  = '0;
                    received_sum_next = '0;
                    held_id_next      = '0;
                end else begin
                    phase_next        = PH_BODY;
                    frame_length_next = rx_byte;
                    byte_count_next   = '0;
                    received_sum_next = '0;
                    running_sum_next  = sum_plus;
                end
            end
            PH_BODY: begin
                byte_count_next = count_inc;
                if (byte_count_reg < payload_len) begin
                    running_sum_next = sum_plus;
                    if (byte_count_reg == '0) begin
                        held_id_next = rx_byte;
                    end
                    emit           = 1'b1;
                    res.out_byte   = rx_byte;
                    res.byte_index = byte_count_reg;
                end else begin
                    received_sum_next = received_ins;
                    if (count_inc >= frame_length_reg) begin
                        emit              = 1'b1;
                        end_now           = 1'b1;
                        res.frame_end     = 1'b1;
                        res.checksum_ok   =
                            (received_ins == {{(CHK_W-SUM_W){1'b0}}, running_sum_reg});
                        res.message_id    = held_id_reg;
                        phase_next        = PH_HUNT;
                        frame_length_next = '0;
                        byte_count_next   = '0;
                        running_sum_next  = '0;
                        received_sum_next = '0;
                        held_id_next      = '0;
                    end
                end
            end
            default: begin
                // hunting, also the unused phase code
                if (rx_byte == sync_byte) begin
                    phase_next        = PH_LEN;
                    frame_length_next = '0;
                    byte_count_next   = '0;
                    running_sum_next  = {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
                    received_sum_next = '0;
                    held_id_next      = '0;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign res_valid = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            running_sum_reg  <= '0;
            received_sum_reg <= '0;
            held_id_reg      <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            received_sum_reg <= received_sum_next;
            held_id_reg      <= held_id_next;
        end
    end

    body_bounds_a: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |->
            frame_length_reg >= MIN_FRAME_LEN && byte_count_reg < frame_length_reg)
        else $error("body counter out of frame bounds");

    len_clean_a: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LEN |-> byte_count_reg == '0 && received_sum_reg == '0)
        else $error("length phase with stale frame state");

    end_rehunt_a: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_now |=> phase_reg == PH_HUNT && running_sum_reg == '0)
        else $error("frame end did not return to hunting");

    end_is_result_a: assert property (@(posedge aclk) disable iff (!aresetn)
        end_now |-> emit && phase_reg == PH_BODY)
        else $error("frame end outside body phase");

endmodule

### hdl/slsf_out_reg.sv
module slsf_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  slsf_pkg::result_t   in_res,
    output logic                in_ready,
    output logic                out_valid,
    output slsf_pkg::result_t   out_res,
    input  logic                out_ready
);
    import slsf_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // slot frees up in the same cycle it drains
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

### hdl/sync_length_sum_framer.sv
// Byte-serial frame parser. Bytes enter on the s_ stream one per request; the
// block hunts for the sync byte, takes a length byte L (5 <= L < max_length,
// else it drops back to hunting), then L body bytes. The first L-4 body bytes
// are payload and each leaves on the m_ stream with its index; the last four
// are a little-endian sum of sync, length and payload bytes. The final one
// gives a single request with m_tlast high carrying checksum verdict and id.
// Registers are written through cfg_we/cfg_addr/cfg_wdata (index 0 sync byte,
// index 1 max length); the user must write them only while no frame is in
// flight, which the block does not enforce. One byte per cycle is taken while
// s_tready is high; the parse state updates in the accepting cycle and a result
// register raises m_tvalid in the next cycle. s_tready drops only while the
// result register is full and m_tready is low. Synchronous reset returns to
// hunting, empties the result register and loads sync 0x55, max length 200.
module sync_length_sum_framer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] out_byte, [15:8] byte_index, [16] checksum_ok, [24:17] message_id, rest zero
    output logic [31:0]                  m_tdata,
    output logic                         m_tlast,   // frame_end
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [7:0]                   cfg_wdata
);
    import slsf_pkg::*;

    logic [BYTE_W-1:0] sync_byte_reg;
    logic [BYTE_W-1:0] max_length_reg;
    logic              accept;
    logic              res_valid;
    result_t           res;
    result_t           m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg  <= SYNC_RESET;
            max_length_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SYNC_BYTE:  sync_byte_reg  <= cfg_wdata;
                REG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    slsf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .sync_byte  (sync_byte_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    slsf_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (m_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {7'd0, m_res.message_id, m_res.checksum_ok,
                      m_res.byte_index, m_res.out_byte};
    assign m_tlast = m_res.frame_end;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import slsf_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = REG_SYNC_BYTE;
    logic [7:0]  cfg_wdata = '0;

    always #CLK_HALF aclk = ~aclk;

    sync_length_sum_framer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    logic [7:0] rx_bytes[$];
    result_t    frame_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int err_cnt        = 0;
    int quiet_cycles   = 0;
    int pushed         = 0;

    // parser copy, tracking the block at request level
    logic [7:0]  cur_sync    = SYNC_RESET;
    logic [7:0]  cur_max_len = MAX_LEN_RESET;
    phase_t      ph          = PH_HUNT;
    logic [7:0]  frm_len     = '0;
    logic [7:0]  body_cnt    = '0;
    logic [31:0] byte_sum    = '0;
    logic [31:0] rx_sum      = '0;
    logic [7:0]  frame_id    = '0;

    function automatic void drop_frame();
        ph       = PH_HUNT;
        frm_len  = '0;
        body_cnt = '0;
        byte_sum = '0;
        rx_sum   = '0;
        frame_id = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, output bit has,
                                       output result_t r);
        int payload;
        int pos;
        r   = '0;
        has = 1'b0;
        case (ph)
            PH_LEN: begin
                if (b < MIN_FRAME_LEN || b >= cur_max_len) begin
                    drop_frame();
                end else begin
                    frm_len  = b;
                    body_cnt = '0;
                    rx_sum   = '0;
                    byte_sum = byte_sum + 32'(b);
                    ph       = PH_BODY;
                end
            end
            PH_BODY: begin
                payload = int'(frm_len) - int'(SUM_BYTES);
                pos     = int'(body_cnt);
                if (pos < payload) begin
                    byte_sum = byte_sum + 32'(b);
                    if (pos == 0) frame_id = b;
                    body_cnt     = 8'(pos + 1);
                    r.out_byte   = b;
                    r.byte_index = 8'(pos);
                    has          = 1'b1;
                end else begin
                    // checksum arrives little endian
                    rx_sum   = rx_sum | (32'(b) << (8 * ((pos - payload) & 3)));
                    body_cnt = 8'(pos + 1);
                    if (body_cnt >= frm_len) begin
                        r.frame_end   = 1'b1;
                        r.checksum_ok = (rx_sum == byte_sum);
                        r.message_id  = frame_id;
                        has           = 1'b1;
                        drop_frame();
                    end
                end
            end
            default: begin
                if (b == cur_sync) begin
                    drop_frame();
                    byte_sum = 32'(b);
                    ph       = PH_LEN;
                end else begin
                    ph = PH_HUNT;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR at %0t: %s, expected %0h, got %0h", $time, what, want, got);
        err_cnt++;
    endtask

    // byte sender
    always @(posedge aclk) begin : byte_driver
        bit      has;
        result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, has, r);
                if (has) frame_results.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (rx_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with the long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_results.size() == 0) begin
                report_mismatch("result with none expected", '0, m_tdata);
            end else begin
                want = frame_results.pop_front();
                if (m_tdata[7:0] !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
                if (m_tdata[15:8] !== want.byte_index)
                    report_mismatch("byte_index", 32'(want.byte_index),
                                    32'(m_tdata[15:8]));
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", 32'(want.frame_end), 32'(m_tlast));
                if (m_tdata[16] !== want.checksum_ok)
                    report_mismatch("checksum_ok", 32'(want.checksum_ok),
                                    32'(m_tdata[16]));
                if (m_tdata[24:17] !== want.message_id)
                    report_mismatch("message_id", 32'(want.message_id),
                                    32'(m_tdata[24:17]));
                if (m_tdata[31:25] !== '0)
                    report_mismatch("tdata pad bits", '0, 32'(m_tdata[31:25]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_length_sum_framer: mismatch");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes.push_back(b);
        pushed++;
    endtask

    // fill < 0 gives random payload
    task automatic add_frame(input int len, input bit bad_sum, input int fill);
        logic [31:0] sum;
        logic [7:0]  d;
        sum = 32'(cur_sync) + 32'(len);
        push_byte(cur_sync);
        push_byte(8'(len));
        for (int i = 0; i < len - 4; i++) begin
            d = (fill < 0) ? 8'($urandom_range(255, 0)) : 8'(fill);
            sum = sum + 32'(d);
            push_byte(d);
        end
        if (bad_sum) sum = sum ^ (32'd1 << $urandom_range(31, 0));
        for (int k = 0; k < 4; k++) push_byte(sum[8*k +: 8]);
    endtask

    task automatic add_traffic(input int n);
        int start;
        int pick;
        int hi;
        int len;
        start = pushed;
        hi    = int'(cur_max_len) - 1;
        while (pushed - start < n) begin
            pick = $urandom_range(99, 0);
            if ($urandom_range(99, 0) < 90)
                len = $urandom_range((hi < 20) ? hi : 20, 5);
            else
                len = $urandom_range(hi, 5);
            if (pick < 70) begin
                add_frame(len, $urandom_range(99, 0) < 15, -1);
            end else if (pick < 80) begin
                push_byte(8'($urandom_range(255, 0)));
            end else if (pick < 88) begin
                push_byte(cur_sync);
                if ($urandom_range(1, 0))
                    push_byte(8'($urandom_range(int'(MIN_FRAME_LEN) - 1, 0)));
                else
                    push_byte(8'($urandom_range(255, int'(cur_max_len))));
            end else begin
                // cut-off frame
                push_byte(cur_sync);
                push_byte(8'(len));
                repeat ($urandom_range(len - 1, 0)) push_byte(8'($urandom_range(255, 0)));
            end
        end
    endtask

    task automatic write_reg(input logic addr, input logic [7:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        if (addr == REG_SYNC_BYTE) cur_sync = data;
        else cur_max_len = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // drain everything, then finish any open frame so the parser is hunting
    task automatic settle();
        do begin
            while (rx_bytes.size() != 0 || s_tvalid || frame_results.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            if (ph == PH_LEN)
                push_byte('0);
            else if (ph == PH_BODY)
                repeat (int'(frm_len) - int'(body_cnt)) push_byte(8'($urandom_range(255, 0)));
        end while (ph != PH_HUNT);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, no idling, then a long receiver hold-off
        push_byte(8'h00);
        push_byte(8'hFF);
        add_frame(5, 1'b0, 255);
        add_frame(6, 1'b1, 0);
        push_byte(cur_sync);
        push_byte(8'd4);
        push_byte(cur_sync);
        push_byte(MAX_LEN_RESET);
        add_traffic(280);
        @(negedge aclk);
        hold_left <= HOLD_CYCLES;
        settle();

        write_reg(REG_SYNC_BYTE, 8'h00);
        write_reg(REG_MAX_LENGTH, 8'd255);
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        add_frame(254, 1'b0, -1);
        add_traffic(200);
        settle();

        // only length 5 fits; a length byte equal to sync must not restart
        write_reg(REG_SYNC_BYTE, 8'hFF);
        write_reg(REG_MAX_LENGTH, 8'd6);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        push_byte(8'hFF);
        push_byte(8'hFF);
        add_frame(5, 1'b0, -1);
        add_traffic(250);
        settle();

        write_reg(REG_SYNC_BYTE, 8'($urandom_range(255, 0)));
        write_reg(REG_MAX_LENGTH, 8'($urandom_range(255, 6)));
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        add_traffic(350);
        settle();

        write_reg(REG_SYNC_BYTE, SYNC_RESET);
        write_reg(REG_MAX_LENGTH, MAX_LEN_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_traffic(300);
        settle();

        if (err_cnt == 0)
            $display("sync_length_sum_framer: match");
        else
            $display("sync_length_sum_framer: mismatch");
        $finish;
    end

endmodule

### sim.f
hdl/slsf_pkg.sv
hdl/slsf_parser.sv
hdl/slsf_out_reg.sv
hdl/sync_length_sum_framer.sv
test/tb_top.sv
